// ===== hdl/link_loss_permit_latch_assert.svh =====
// Assertion macros for the link loss permit latch.
`ifndef LINK_LOSS_PERMIT_LATCH_ASSERT_SVH
`define LINK_LOSS_PERMIT_LATCH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LLPL_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define LLPL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define LLPL_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)
`define LLPL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== hdl/llpl_pkg.sv =====
// Shared constants for the link loss permit latch.
package llpl_pkg;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_LOW       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_HIGH      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECOVER_HOLD   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LATCH_TIMEOUT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECONN_GRACE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECONN_PERIOD  = 3'd5;

    localparam int BAND_LOW_RESET      = 700;
    localparam int BAND_HIGH_RESET     = 1300;
    localparam int RECOVER_HOLD_RESET  = 50;
    localparam int LATCH_TIMEOUT_RESET = 250;
    localparam int RECONN_GRACE_RESET  = 25;
    localparam int RECONN_PERIOD_RESET = 50;

    localparam logic [1:0] ZONE_UNKNOWN = 2'd0;
    localparam logic [1:0] ZONE_CENTER  = 2'd1;
    localparam logic [1:0] ZONE_EXTREME = 2'd2;

endpackage

// ===== hdl/link_loss_permit_latch.sv =====
// Link loss permit latch: zone classifier, link state machine and reconnect pacing.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  in       | in_valid / in_ready     | link_up, switch_value
//  out      | out_valid / out_ready   | permit, link_ok, link_state, switch_zone,
//           |                         | reconnect_request
//  cfg      | cfg_write_en            | cfg_index, cfg_data
//
// One request per cycle unless out_ready stalls the output: an input register feeds the state
// update and the result register, so each request passes through both registers to the output.
// All state (link machine, streak and age counters) updates when the result register loads.
// While a result waits on out_ready the input register takes one more request,
// then in_ready stays low until out_ready returns.
// Reset: machine ok, ages zero, request timer saturated, registers at defaults.
`include "link_loss_permit_latch_assert.svh"
module link_loss_permit_latch
    import llpl_pkg::*;
#(
    parameter int TIMER_BITS   = 16,
    parameter int CHANNEL_BITS = 11,
    localparam int CFG_BITS    = (TIMER_BITS > CHANNEL_BITS) ? TIMER_BITS : CHANNEL_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      link_up,
    input  logic [CHANNEL_BITS-1:0]   switch_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      permit,
    output logic                      link_ok,
    output logic [1:0]                link_state,
    output logic [1:0]                switch_zone,
    output logic                      reconnect_request,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOST    = 2'd1,
        ST_LATCHED = 2'd2
    } link_state_t;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        sat_inc = (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    // configuration
    logic [CHANNEL_BITS-1:0] band_low_reg;
    logic [CHANNEL_BITS-1:0] band_high_reg;
    logic [TIMER_BITS-1:0]   hold_reg;
    logic [TIMER_BITS-1:0]   timeout_reg;
    logic [TIMER_BITS-1:0]   grace_reg;
    logic [TIMER_BITS-1:0]   period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg  <= CHANNEL_BITS'(BAND_LOW_RESET);
            band_high_reg <= CHANNEL_BITS'(BAND_HIGH_RESET);
            hold_reg      <= TIMER_BITS'(RECOVER_HOLD_RESET);
            timeout_reg   <= TIMER_BITS'(LATCH_TIMEOUT_RESET);
            grace_reg     <= TIMER_BITS'(RECONN_GRACE_RESET);
            period_reg    <= TIMER_BITS'(RECONN_PERIOD_RESET);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_BAND_LOW:      band_low_reg  <= cfg_data[CHANNEL_BITS-1:0];
                REG_BAND_HIGH:     band_high_reg <= cfg_data[CHANNEL_BITS-1:0];
                REG_RECOVER_HOLD:  hold_reg      <= cfg_data[TIMER_BITS-1:0];
                REG_LATCH_TIMEOUT: timeout_reg   <= cfg_data[TIMER_BITS-1:0];
                REG_RECONN_GRACE:  grace_reg     <= cfg_data[TIMER_BITS-1:0];
                REG_RECONN_PERIOD: period_reg    <= cfg_data[TIMER_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    logic                    s1_valid_reg;
    logic                    s1_link_reg;
    logic [CHANNEL_BITS-1:0] s1_value_reg;
    logic                    out_valid_reg;
    logic                    advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_link_reg  <= link_up;
            s1_value_reg <= switch_value;
        end
    end

    // tick state
    link_state_t           state_reg, state_next;
    logic                  prev_link_reg;
    logic                  primed_reg;
    logic                  ack_reg, ack_next;
    logic [TIMER_BITS-1:0] good_reg, good_next;
    logic [TIMER_BITS-1:0] bad_reg, bad_next;
    logic [TIMER_BITS-1:0] lost_reg, lost_next;
    logic [TIMER_BITS-1:0] since_reg, since_next;
    logic                  request_next;
    logic [1:0]            zone_next;
    logic                  stable;

    always_comb
    begin
        since_next   = sat_inc(since_reg);
        lost_next    = sat_inc(lost_reg);
        request_next = 1'b0;
        good_next    = '0;
        bad_next     = '0;
        if (!s1_link_reg)
        begin
            bad_next = (prev_link_reg || !primed_reg) ? '0 : sat_inc(bad_reg);
            if (bad_next >= grace_reg && since_next >= period_reg)
            begin
                request_next = 1'b1;
                since_next   = '0;
            end
        end
        else
        begin
            good_next = prev_link_reg ? sat_inc(good_reg) : '0;
        end

        if (!s1_link_reg)
            zone_next = ZONE_UNKNOWN;
        else if (s1_value_reg >= band_low_reg && s1_value_reg <= band_high_reg)
            zone_next = ZONE_CENTER;
        else
            zone_next = ZONE_EXTREME;

        stable     = s1_link_reg && (good_next >= hold_reg);
        state_next = state_reg;
        ack_next   = ack_reg;
        case (state_reg)
            ST_OK:
            begin
                if (!s1_link_reg)
                begin
                    lost_next  = '0;
                    ack_next   = 1'b0;
                    state_next = ST_LOST;
                end
            end
            ST_LOST:
            begin
                if (stable)
                    state_next = ST_OK;
                else if (lost_next >= timeout_reg)
                    state_next = ST_LATCHED;
            end
            default:
            begin
                // leave the latch only after extreme, then back to center on a stable link
                if (zone_next == ZONE_EXTREME)
                    ack_next = 1'b1;
                if (stable && ack_next && zone_next == ZONE_CENTER)
                    state_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_OK;
            prev_link_reg <= 1'b0;
            primed_reg    <= 1'b0;
            ack_reg       <= 1'b0;
            good_reg      <= '0;
            bad_reg       <= '0;
            lost_reg      <= '0;
            since_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                prev_link_reg <= s1_link_reg;
                primed_reg    <= 1'b1;
                ack_reg       <= ack_next;
                good_reg      <= good_next;
                bad_reg       <= bad_next;
                lost_reg      <= lost_next;
                since_reg     <= since_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            permit            <= (state_next == ST_OK) && (zone_next == ZONE_CENTER);
            link_ok           <= s1_link_reg;
            link_state        <= state_next;
            switch_zone       <= zone_next;
            reconnect_request <= request_next;
        end
    end

    assign out_valid = out_valid_reg;

    `LLPL_ASSERT_IMPL(a_request_only_when_down, clk, rst_n, out_valid && reconnect_request,
        !link_ok, "reconnect request on a healthy link")
    `LLPL_ASSERT_IMPL(a_zone_unknown_iff_down, clk, rst_n, out_valid,
        (switch_zone == ZONE_UNKNOWN) == !link_ok, "zone disagrees with link health")
    `LLPL_ASSERT_NEXT(a_no_direct_latch, clk, rst_n, state_reg == ST_OK,
        state_reg != ST_LATCHED, "latched without passing through lost transient")
    `LLPL_ASSERT_IMPL(a_permit_needs_ok, clk, rst_n, out_valid && permit,
        link_state == ST_OK && link_ok, "permit while link not ok")

endmodule

// ===== test/tb_link_loss_permit_latch.sv =====
// Testbench for the link loss permit latch: random poll ticks checked against a local predictor.
`timescale 1ns / 1ps

module tb_link_loss_permit_latch;
    import llpl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOST    = 2'd1,
        ST_LATCHED = 2'd2
    } link_state_t;

    typedef struct packed {
        logic        link;
        logic [10:0] value;
    } poll_t;

    typedef struct packed {
        logic       permit;
        logic       link_ok;
        logic [1:0] state;
        logic [1:0] zone;
        logic       reconnect;
    } verdict_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      link_up = 1'b0;
    logic [10:0]               switch_value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      permit;
    logic                      link_ok;
    logic [1:0]                link_state;
    logic [1:0]                switch_zone;
    logic                      reconnect_request;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [15:0]               cfg_data = '0;

    // register copies
    logic [10:0] band_low_reg    = 11'(BAND_LOW_RESET);
    logic [10:0] band_high_reg   = 11'(BAND_HIGH_RESET);
    logic [15:0] hold_reg        = 16'(RECOVER_HOLD_RESET);
    logic [15:0] timeout_reg     = 16'(LATCH_TIMEOUT_RESET);
    logic [15:0] grace_reg       = 16'(RECONN_GRACE_RESET);
    logic [15:0] period_reg      = 16'(RECONN_PERIOD_RESET);

    // predicted link machine
    link_state_t link_st    = ST_OK;
    logic        prev_link  = 1'b0;
    logic        primed     = 1'b0;
    logic        ack_seen   = 1'b0;
    logic [15:0] good_age   = '0;
    logic [15:0] bad_age    = '0;
    logic [15:0] lost_age   = '0;
    logic [15:0] since_req  = 16'hFFFF;

    poll_t    pending_polls[$];
    verdict_t expected_verdicts[$];
    poll_t    next_poll;
    verdict_t want;

    int  queued_total = 0;
    int  results_seen = 0;
    int  fail_count = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    logic send_hold = 1'b0;
    int  stall_asks = 0;
    int  stall_served = 0;
    int  stall_left = 0;
    logic [8:0] rx_cycle = '0;
    int  idle_cycles = 0;

    link_loss_permit_latch dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .link_up           (link_up),
        .switch_value      (switch_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .permit            (permit),
        .link_ok           (link_ok),
        .link_state        (link_state),
        .switch_zone       (switch_zone),
        .reconnect_request (reconnect_request),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] sat_bump(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    // Advance the predicted machine by one poll tick and return its result.
    function automatic verdict_t next_verdict(input logic link, input logic [10:0] value);
        verdict_t   v;
        logic [1:0] zone;
        logic       stable;
        logic       req;
        req = 1'b0;
        since_req = sat_bump(since_req);
        lost_age = sat_bump(lost_age);
        if (!link)
        begin
            bad_age = (prev_link || !primed) ? 16'd0 : sat_bump(bad_age);
            if (bad_age >= grace_reg && since_req >= period_reg)
            begin
                req = 1'b1;
                since_req = '0;
            end
            good_age = '0;
        end
        else
        begin
            good_age = prev_link ? sat_bump(good_age) : 16'd0;
            bad_age = '0;
        end
        prev_link = link;
        primed = 1'b1;

        if (!link)
            zone = ZONE_UNKNOWN;
        else if (value >= band_low_reg && value <= band_high_reg)
            zone = ZONE_CENTER;
        else
            zone = ZONE_EXTREME;
        stable = link && good_age >= hold_reg;

        case (link_st)
            ST_OK:
            begin
                if (!link)
                begin
                    lost_age = '0;
                    ack_seen = 1'b0;
                    link_st = ST_LOST;
                end
            end
            ST_LOST:
            begin
                if (stable)
                    link_st = ST_OK;
                else if (lost_age >= timeout_reg)
                    link_st = ST_LATCHED;
            end
            default:
            begin
                // clear the latch only after an extreme, then center on a stable link
                if (zone == ZONE_EXTREME)
                    ack_seen = 1'b1;
                if (stable && ack_seen && zone == ZONE_CENTER)
                    link_st = ST_OK;
            end
        endcase

        v.permit = (link_st == ST_OK && zone == ZONE_CENTER);
        v.link_ok = link;
        v.state = link_st;
        v.zone = zone;
        v.reconnect = req;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                results_seen, name, got, exp_val));
    endtask

    // Driver: bursts of requests with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_verdicts.push_back(next_verdict(link_up, switch_value));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || send_hold || pending_polls.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    next_poll = pending_polls.pop_front();
                    link_up <= next_poll.link;
                    switch_value <= next_poll.value;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: check each result, stall on a rotating pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            rx_cycle <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                        results_seen));
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("permit", permit, want.permit);
                    check_field("link_ok", link_ok, want.link_ok);
                    check_field("link_state", link_state, want.state);
                    check_field("switch_zone", switch_zone, want.zone);
                    check_field("reconnect_request", reconnect_request, want.reconnect);
                end
                results_seen++;
            end
            rx_cycle <= rx_cycle + 1'b1;
            if (stall_served != stall_asks)
            begin
                stall_served <= stall_asks;
                stall_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[8:6])
                    3'd0, 3'd1: out_ready <= 1'b1;
                    3'd2, 3'd3: out_ready <= 1'($urandom_range(0, 1));
                    3'd4:       out_ready <= ($urandom_range(0, 3) == 0);
                    3'd5:       out_ready <= rx_cycle[2];
                    default:    out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_poll(input logic link, input logic [10:0] value);
        poll_t p;
        p.link = link;
        p.value = value;
        pending_polls.push_back(p);
        queued_total++;
    endtask

    function automatic int near(input int t);
        if (t > 40)
            return $urandom_range(1, 40);
        return $urandom_range((t > 1) ? t - 1 : 1, t + 2);
    endfunction

    function automatic logic [10:0] pick_value(input logic centered);
        int lo;
        int hi;
        int r;
        lo = band_low_reg;
        hi = band_high_reg;
        r = $urandom_range(0, 5);
        if (centered && lo <= hi)
            return 11'((r == 0) ? lo : (r == 1) ? hi : $urandom_range(lo, hi));
        if (!centered && lo > 0 && (hi == 2047 || r < 3))
            return 11'((r == 0) ? lo - 1 : $urandom_range(0, lo - 1));
        if (!centered && hi < 2047)
            return 11'((r == 3) ? hi + 1 : $urandom_range(hi + 1, 2047));
        return 11'($urandom_range(0, 2047));
    endfunction

    // Queue well-formed link episodes with some noise mixed in.
    task automatic queue_scenarios(input int count);
        int target;
        int len;
        int i;
        target = queued_total + count;
        while (queued_total < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    len = near(hold_reg);
                    for (i = 0; i < len; i++)
                        push_poll(1'b1, pick_value($urandom_range(0, 7) != 0));
                end
                3, 4:
                begin
                    case ($urandom_range(0, 2))
                        0:       len = near(grace_reg);
                        1:       len = near(grace_reg + period_reg);
                        default: len = near(timeout_reg);
                    endcase
                    for (i = 0; i < len; i++)
                        push_poll(1'b0, 11'($urandom_range(0, 2047)));
                end
                5, 6:
                begin
                    // latch, then acknowledge with an extreme and return to center
                    len = near(timeout_reg) + 1;
                    for (i = 0; i < len; i++)
                        push_poll(1'b0, 11'($urandom_range(0, 2047)));
                    len = $urandom_range(0, 2);
                    for (i = 0; i < len; i++)
                        push_poll(1'b1, pick_value(1'b1));
                    len = $urandom_range(1, 3);
                    for (i = 0; i < len; i++)
                        push_poll(1'b1, pick_value(1'b0));
                    len = near(hold_reg) + 1;
                    for (i = 0; i < len; i++)
                        push_poll(1'b1, pick_value(1'b1));
                end
                7:
                begin
                    len = $urandom_range(1, 8);
                    for (i = 0; i < len; i++)
                        push_poll(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)));
                end
                8:
                begin
                    len = $urandom_range(2, 10);
                    for (i = 0; i < len; i++)
                        push_poll(i[0], pick_value(1'($urandom_range(0, 1))));
                end
                default:
                begin
                    len = near(hold_reg);
                    for (i = 0; i < len; i++)
                        push_poll(1'b1, pick_value(1'b0));
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_BAND_LOW:      band_low_reg = data[10:0];
            REG_BAND_HIGH:     band_high_reg = data[10:0];
            REG_RECOVER_HOLD:  hold_reg = data;
            REG_LATCH_TIMEOUT: timeout_reg = data;
            REG_RECONN_GRACE:  grace_reg = data;
            default:           period_reg = data;
        endcase
    endtask

    task automatic apply_setting(input int lo, input int hi, input int hold,
                                 input int tmo, input int grace, input int period);
        write_reg(REG_BAND_LOW, 16'(lo));
        write_reg(REG_BAND_HIGH, 16'(hi));
        write_reg(REG_RECOVER_HOLD, 16'(hold));
        write_reg(REG_LATCH_TIMEOUT, 16'(tmo));
        write_reg(REG_RECONN_GRACE, 16'(grace));
        write_reg(REG_RECONN_PERIOD, 16'(period));
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_polls.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bad first tick, then band edges and all-ones / all-zeros values
        push_poll(1'b0, 11'h7FF);
        push_poll(1'b0, 11'h000);
        push_poll(1'b1, 11'h000);
        push_poll(1'b1, 11'h7FF);
        push_poll(1'b1, 11'd699);
        push_poll(1'b1, 11'd700);
        push_poll(1'b1, 11'd1300);
        push_poll(1'b1, 11'd1301);
        push_poll(1'b1, 11'd1000);
        push_poll(1'b1, 11'h555);
        push_poll(1'b1, 11'h2AA);
        push_poll(1'b0, 11'd1000);
        push_poll(1'b1, 11'd1000);
        queue_scenarios(150);

        // hold the sender until the block has drained
        while (pending_polls.size() > 70)
            @(negedge clk);
        send_hold <= 1'b1;
        @(negedge clk);
        while (in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        send_hold <= 1'b0;
        wait_idle();

        apply_setting(700, 1300, 3, 6, 2, 4);
        queue_scenarios(200);
        // long receiver stall while requests keep coming
        stall_asks <= stall_asks + 1;
        wait_idle();

        apply_setting(0, 2047, 0, 0, 0, 0);
        queue_scenarios(120);
        wait_idle();

        apply_setting(1500, 400, 5, 10, 3, 7);
        queue_scenarios(120);
        wait_idle();

        apply_setting(1024, 1024, 1, 2, 1, 1);
        queue_scenarios(100);
        wait_idle();

        apply_setting(2047, 2047, 65535, 65535, 65535, 65535);
        queue_scenarios(80);
        wait_idle();

        repeat (2)
        begin
            apply_setting($urandom_range(0, 2047), $urandom_range(0, 2047),
                $urandom_range(0, 12), $urandom_range(0, 12),
                $urandom_range(0, 12), $urandom_range(0, 12));
            queue_scenarios(100);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/llpl_pkg.sv
hdl/link_loss_permit_latch.sv
test/tb_link_loss_permit_latch.sv
